// ===== rtl/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants for the serial command frame parser.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Header bytes that open every frame.
  localparam logic [7:0] HDR_FIRST  = 8'h3F;
  localparam logic [7:0] HDR_SECOND = 8'h43;

  // Largest payload any frame may carry.
  localparam int unsigned FRAME_CAP = 64;

  // Default depth of the payload buffer.
  localparam int unsigned DEFAULT_BUFFER_DEPTH = 64;

  // Reset value of the maximum payload register.
  localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

  // Parser phases, including the result readout steps.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SIZE,
    PH_CMD,
    PH_DATA,
    PH_STATUS,
    PH_FETCH,
    PH_LOAD
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic size_load;
    logic cmd_load;
    logic data_store;
    logic csum_latch;
    logic rd_fetch;
    logic out_load_status;
    logic out_load_data;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_first;
    logic hdr_second;
    logic size_ok;
    logic fill_lt_len;
    logic csum_match;
    logic len_nz;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/serial_command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core
// Receives command frames byte by byte and reports each completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_rx_byte) moves one received byte
//   per transfer. A frame is '?' 'C', size, command, payload, checksum.
//   The output channel (out_valid/out_ready/out_*) gives the results of a
//   frame once its checksum byte is taken: one status result for a bad
//   checksum or an empty payload, otherwise one result per payload byte,
//   the final result carrying out_last.
//   Header, size, command and payload bytes are taken whenever offered.
//   After the checksum byte, a status result passes through the status
//   phase into the result register; a payload readout gives each result
//   through a buffer read in the fetch phase followed by the load of the
//   result register in the load phase. in_ready stays low from the
//   checksum transfer until the last result is in the result register.
//   A stalled receiver holds the result register and pauses the readout.
//   cfg_wr_en/cfg_wr_data set the largest accepted size (reset 64).
//   Reset (synchronous, rst_n low) returns the parser to header hunting and
//   drops any pending result; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_command_code,
  output logic [6:0] out_frame_length,
  output logic       out_checksum_ok,
  output logic       out_has_payload,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);
  import scf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Frame phase controller.
  scf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame datapath and result register.
  scf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_data      (cfg_wr_data),
    .cfg_wr_en        (cfg_wr_en),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_command_code (out_command_code),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok),
    .out_has_payload  (out_has_payload),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

// ===== rtl/scf_ctrl.sv =====
// ----------------------------------------------------------------------------
// scf_ctrl
// Phase controller: walks the frame layout and sequences the result readout.
// ----------------------------------------------------------------------------
module scf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scf_pkg::dp_stat_t stat,
  output scf_pkg::ctl_cmd_t cmd
);
  import scf_pkg::*;

  phase_t phase_r;
  phase_t phase_nxt;
  logic   fire;

  // Bytes are taken only in the parsing phases.
  always_comb begin
    in_ready = (phase_r == PH_IDLE) || (phase_r == PH_START) || (phase_r == PH_SIZE) ||
               (phase_r == PH_CMD) || (phase_r == PH_DATA);
    fire = in_valid && in_ready;
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (fire) phase_nxt = stat.hdr_first ? PH_START : PH_IDLE;
      end
      PH_START: begin
        if (fire) phase_nxt = stat.hdr_second ? PH_SIZE : PH_IDLE;
      end
      PH_SIZE: begin
        if (fire) phase_nxt = stat.size_ok ? PH_CMD : PH_IDLE;
      end
      PH_CMD: begin
        if (fire) phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (fire && !stat.fill_lt_len) begin
          phase_nxt = (stat.csum_match && stat.len_nz) ? PH_FETCH : PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (stat.out_free) phase_nxt = PH_IDLE;
      end
      PH_FETCH: begin
        phase_nxt = PH_LOAD;
      end
      PH_LOAD: begin
        if (stat.out_free) phase_nxt = stat.rd_last ? PH_IDLE : PH_FETCH;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd                 = '0;
    cmd.size_load       = (phase_r == PH_SIZE) && fire && stat.size_ok;
    cmd.cmd_load        = (phase_r == PH_CMD) && fire;
    cmd.data_store      = (phase_r == PH_DATA) && fire && stat.fill_lt_len;
    cmd.csum_latch      = (phase_r == PH_DATA) && fire && !stat.fill_lt_len;
    cmd.rd_fetch        = (phase_r == PH_FETCH);
    cmd.out_load_status = (phase_r == PH_STATUS) && stat.out_free;
    cmd.out_load_data   = (phase_r == PH_LOAD) && stat.out_free;
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/scf_dp.sv =====
// ----------------------------------------------------------------------------
// scf_dp
// Datapath: frame fields, running checksum, payload buffer and result register.
// ----------------------------------------------------------------------------
module scf_dp #(
  parameter int unsigned BUFFER_DEPTH = scf_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        cfg_wr_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        in_rx_byte,
  input  scf_pkg::ctl_cmd_t cmd,
  output scf_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_command_code,
  output logic [6:0]        out_frame_length,
  output logic              out_checksum_ok,
  output logic              out_has_payload,
  output logic [7:0]        out_payload_byte,
  output logic [5:0]        out_byte_index,
  output logic              out_last
);
  import scf_pkg::*;

  localparam int unsigned AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CAP = (BUFFER_DEPTH < FRAME_CAP) ? BUFFER_DEPTH : FRAME_CAP;
  localparam logic [6:0]  CAP_W = 7'(CAP);

  logic [6:0]    max_r;
  logic [6:0]    len_r;
  logic [6:0]    fill_r;
  logic [7:0]    xor_r;
  logic [7:0]    cmd_r;
  logic          ok_r;
  logic [5:0]    rd_idx_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [BUFFER_DEPTH];
  logic [6:0]    limit;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    fill_ext;
  logic [7:0]    rd_ext;
  logic [6:0]    rd_next;

  logic          out_valid_r;
  logic [7:0]    out_cmd_r;
  logic [6:0]    out_len_r;
  logic          out_ok_r;
  logic          out_has_r;
  logic [7:0]    out_byte_r;
  logic [5:0]    out_idx_r;
  logic          out_last_r;

  // Effective size limit and buffer addresses.
  always_comb begin
    limit    = (max_r > CAP_W) ? CAP_W : max_r;
    fill_ext = {1'b0, fill_r};
    rd_ext   = {2'b00, rd_idx_r};
    wr_addr  = fill_ext[AW-1:0];
    rd_addr  = rd_ext[AW-1:0];
    rd_next  = {1'b0, rd_idx_r} + 7'd1;
  end

  // Status toward the controller.
  always_comb begin
    stat.hdr_first   = (in_rx_byte == HDR_FIRST);
    stat.hdr_second  = (in_rx_byte == HDR_SECOND);
    stat.size_ok     = (in_rx_byte <= {1'b0, limit});
    stat.fill_lt_len = (fill_r < len_r);
    stat.csum_match  = (xor_r == in_rx_byte);
    stat.len_nz      = (len_r != 7'd0);
    stat.rd_last     = (rd_next == len_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // Frame fields and running checksum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      fill_r   <= '0;
      xor_r    <= '0;
      cmd_r    <= '0;
      ok_r     <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.size_load) begin
        len_r  <= in_rx_byte[6:0];
        fill_r <= '0;
        xor_r  <= in_rx_byte;
      end
      if (cmd.cmd_load) begin
        cmd_r <= in_rx_byte;
        xor_r <= xor_r ^ in_rx_byte;
      end
      if (cmd.data_store) begin
        xor_r  <= xor_r ^ in_rx_byte;
        fill_r <= fill_r + 7'd1;
      end
      if (cmd.csum_latch) begin
        ok_r     <= stat.csum_match;
        rd_idx_r <= '0;
      end
      if (cmd.out_load_data) begin
        rd_idx_r <= rd_next[5:0];
      end
    end
  end

  // Payload buffer with registered read.
  always_ff @(posedge clk) begin
    if (cmd.data_store) begin
      mem[wr_addr] <= in_rx_byte;
    end
    if (cmd.rd_fetch) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register: holds one result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load_status || cmd.out_load_data) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_status) begin
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r;
      out_ok_r   <= ok_r;
      out_has_r  <= 1'b0;
      out_byte_r <= '0;
      out_idx_r  <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.out_load_data) begin
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r;
      out_ok_r   <= 1'b1;
      out_has_r  <= 1'b1;
      out_byte_r <= rd_data_r;
      out_idx_r  <= rd_idx_r;
      out_last_r <= stat.rd_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_code = out_cmd_r;
  assign out_frame_length = out_len_r;
  assign out_checksum_ok  = out_ok_r;
  assign out_has_payload  = out_has_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_last         = out_last_r;

endmodule

// ===== dv/serial_command_frame_parser_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core_test
// Drives byte streams into the frame parser and checks every frame report.
// A built-in parser model follows each accepted byte and queues the results
// it owes; a monitor pops them in order as the block hands results over.
// Both channels stall in random bursts, except in the final back-to-back run.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core_test;
  import scf_pkg::*;

  localparam int unsigned STORE_DEPTH = DEFAULT_BUFFER_DEPTH;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One frame report, laid out as the result channel presents it.
  typedef struct packed {
    logic [7:0] command_code;
    logic [6:0] frame_length;
    logic       checksum_ok;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } frame_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = 7'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_command_code;
  logic [6:0] out_frame_length;
  logic       out_checksum_ok;
  logic       out_has_payload;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_last;

  // Parser model state and the register copy.
  phase_t      mdl_phase;
  logic [6:0]  mdl_max;
  logic [6:0]  mdl_len;
  logic [6:0]  mdl_fill;
  logic [7:0]  mdl_xor;
  logic [7:0]  mdl_cmd;
  logic [7:0]  mdl_store [STORE_DEPTH];

  frame_report_t frame_reports_due[$];

  bit          send_gaps_on = 1'b1;
  bit          ready_gaps_on = 1'b1;
  int unsigned fault_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_closed = 0;
  int unsigned reports_checked = 0;
  int unsigned limit_writes = 0;
  int unsigned quiet_cycles = 0;

  serial_command_frame_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_frame_length (out_frame_length),
    .out_checksum_ok  (out_checksum_ok),
    .out_has_payload  (out_has_payload),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Largest size byte the parser currently accepts.
  function automatic int unsigned size_cap();
    int unsigned cap;
    cap = mdl_max;
    if (cap > STORE_DEPTH) cap = STORE_DEPTH;
    if (cap > FRAME_CAP) cap = FRAME_CAP;
    return cap;
  endfunction

  task automatic reset_model();
    mdl_phase = PH_IDLE;
    mdl_max = MAX_PAYLOAD_RESET;
    mdl_len = '0;
    mdl_fill = '0;
    mdl_xor = '0;
    mdl_cmd = '0;
    foreach (mdl_store[i]) mdl_store[i] = '0;
  endtask

  // Advance the parser model by one byte and queue the reports it owes.
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_report_t rpt;
    case (mdl_phase)
      PH_START: begin
        // A wrong second header byte is dropped, not retried as a new '?'.
        mdl_phase = (b == HDR_SECOND) ? PH_SIZE : PH_IDLE;
      end
      PH_SIZE: begin
        if (int'(b) > size_cap()) begin
          mdl_phase = PH_IDLE;
        end else begin
          mdl_len = b[6:0];
          mdl_fill = '0;
          mdl_xor = b;
          mdl_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        mdl_cmd = b;
        mdl_xor = mdl_xor ^ b;
        mdl_phase = PH_DATA;
      end
      PH_DATA: begin
        if (mdl_fill < mdl_len) begin
          mdl_xor = mdl_xor ^ b;
          mdl_store[mdl_fill[5:0]] = b;
          mdl_fill = mdl_fill + 7'd1;
        end else begin
          // Checksum byte: close the frame.
          rpt.command_code = mdl_cmd;
          rpt.frame_length = mdl_len;
          rpt.checksum_ok = (mdl_xor == b);
          if (rpt.checksum_ok && mdl_len != 0) begin
            rpt.has_payload = 1'b1;
            for (int i = 0; i < mdl_len; i++) begin
              rpt.payload_byte = mdl_store[i];
              rpt.byte_index = i[5:0];
              rpt.last = (i + 1 == mdl_len);
              frame_reports_due.push_back(rpt);
            end
          end else begin
            rpt.has_payload = 1'b0;
            rpt.payload_byte = '0;
            rpt.byte_index = '0;
            rpt.last = 1'b1;
            frame_reports_due.push_back(rpt);
          end
          frames_closed++;
          mdl_phase = PH_IDLE;
        end
      end
      default: begin
        mdl_phase = (b == HDR_FIRST) ? PH_START : PH_IDLE;
      end
    endcase
  endtask

  // Offer one byte and wait for its transfer. Valid is left high so the
  // next byte can follow without a bubble; waiting paths lower it first.
  task automatic send_byte(input logic [7:0] b);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Stop offering bytes, let every owed report drain, then let the block settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [6:0] value);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_max = value;
    limit_writes++;
  endtask

  // Whole frame with random payload; optionally with a corrupted checksum.
  task automatic send_frame(input int unsigned len, input logic [7:0] cmd,
                            input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] d;
    sum = len[7:0] ^ cmd;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(len[7:0]);
    send_byte(cmd);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      sum = sum ^ d;
      send_byte(d);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Header hunting, an oversized size, empty and bad-checksum status
  // reports, and a short payload with the byte extremes.
  task automatic test_header_and_status();
    // '?' '?' must not restart the header; a lone 'C' is ignored.
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    // Empty frame, good checksum.
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Size one above the reset limit drops the frame.
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'd65);
    // One payload byte, wrong checksum.
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    // Two payload bytes 0x00 and 0xFF, good checksum.
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h02);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h58);
  endtask

  // Register extremes: zero, above the buffer, one, and back to reset.
  task automatic test_size_limits();
    write_max_payload(7'd0);
    send_frame(0, 8'h3C, 1'b0);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'd1);
    send_frame(0, 8'hC3, 1'b1);

    write_max_payload(7'd127);
    send_frame(64, 8'h81, 1'b0);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'd65);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'd127);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);

    write_max_payload(7'd1);
    send_frame(1, 8'h7E, 1'b0);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'd2);

    write_max_payload(MAX_PAYLOAD_RESET);
  endtask

  // Mostly well-formed frames with random content, mixed with bad checksums,
  // oversized sizes, broken headers and line noise.
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned cap;
    int unsigned len;
    logic [7:0]  b;
    first = bytes_sent;
    while (bytes_sent - first < 16) begin
      if ($urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1) == 0) write_max_payload(MAX_PAYLOAD_RESET);
        else write_max_payload(7'($urandom_range(0, 127)));
      end
      cap = size_cap();
      if ($urandom_range(0, 14) == 0) len = $urandom_range(0, cap);
      else len = $urandom_range(0, (cap < 8) ? cap : 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_frame(len, 8'($urandom), 1'b0);
        6: send_frame(len, 8'($urandom), 1'b1);
        7: begin
          send_byte(HDR_FIRST);
          send_byte(HDR_SECOND);
          send_byte(8'($urandom_range(cap + 1, 255)));
        end
        8: begin
          b = 8'($urandom);
          if (b == HDR_SECOND) b = HDR_FIRST;
          send_byte(HDR_FIRST);
          send_byte(b);
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
      endcase
    end
  endtask

  // Full-rate traffic on both channels.
  task automatic test_back_to_back();
    quiesce();
    send_gaps_on = 1'b0;
    ready_gaps_on = 1'b0;
    send_frame(3, 8'($urandom), 1'b0);
    send_frame(0, 8'($urandom), 1'b0);
    send_frame(4, 8'($urandom), 1'b0);
    send_frame(2, 8'($urandom), 1'b1);
    send_frame(1, 8'($urandom), 1'b0);
  endtask

  // Receiver readiness: random stall bursts and ready stretches.
  initial begin : ready_pattern
    forever begin
      if (ready_gaps_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endfunction

  // Check each result transfer against the oldest owed report.
  always @(posedge clk) begin : report_monitor
    frame_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_reports_due.size() == 0) begin
        $error("unexpected result transfer: command 0x%0h index %0d",
               out_command_code, out_byte_index);
        fault_count++;
      end else begin
        want = frame_reports_due.pop_front();
        compare_field("command_code", want.command_code, out_command_code);
        compare_field("frame_length", want.frame_length, out_frame_length);
        compare_field("checksum_ok", want.checksum_ok, out_checksum_ok);
        compare_field("has_payload", want.has_payload, out_has_payload);
        compare_field("payload_byte", want.payload_byte, out_payload_byte);
        compare_field("byte_index", want.byte_index, out_byte_index);
        compare_field("last", want.last, out_last);
        reports_checked++;
      end
    end
  end

  // Watchdog: too long without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d reports still owed",
               QUIET_LIMIT, frame_reports_due.size());
      $display("serial_command_frame_parser_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_header_and_status();
    test_size_limits();
    test_random_traffic();
    test_back_to_back();
    quiesce();

    if (frame_reports_due.size() != 0) begin
      $error("%0d reports never arrived", frame_reports_due.size());
      fault_count++;
    end
    $display("Sent %0d bytes closing %0d frames; checked %0d result transfers.",
             bytes_sent, frames_closed, reports_checked);
    $display("Size limit was rewritten %0d times, extremes included.", limit_writes);
    if (fault_count == 0) begin
      $display("serial_command_frame_parser_core_test: done, clean");
    end else begin
      $display("serial_command_frame_parser_core_test: done, errors");
    end
    $finish;
  end

endmodule
